// ===== rtl/core/cbct_pkg.sv =====
// Package for the color blob centroid tracker: field widths, payload structs,
// register map codes and controller/datapath command types. No dependencies.
`default_nettype none
package cbct_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int AREA       = MAX_WIDTH * MAX_HEIGHT;
	localparam int HARD_CAP   = 1048576;
	localparam int COUNT_CAP  = (AREA < HARD_CAP) ? AREA : HARD_CAP;

	localparam int CH_W    = 8;
	localparam int BOUND_W = 9;
	localparam int COORD_W = 10;
	localparam int CNT_W   = 21;
	localparam int SUM_W   = 30;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 3;

	// The divider produces one quotient bit per step.
	localparam int DIV_STEPS = COORD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [IDX_W-1:0] REG_HUE_LOW  = 3'd0;
	localparam logic [IDX_W-1:0] REG_HUE_HIGH = 3'd1;
	localparam logic [IDX_W-1:0] REG_SAT_LOW  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SAT_HIGH = 3'd3;
	localparam logic [IDX_W-1:0] REG_VAL_LOW  = 3'd4;
	localparam logic [IDX_W-1:0] REG_VAL_HIGH = 3'd5;
	localparam logic [IDX_W-1:0] REG_MIN_AREA = 3'd6;

	localparam logic [CH_W-1:0]    RST_HUE_LOW  = 8'd170;
	localparam logic [BOUND_W-1:0] RST_HUE_HIGH = 9'd180;
	localparam logic [CH_W-1:0]    RST_SAT_LOW  = 8'd160;
	localparam logic [BOUND_W-1:0] RST_SAT_HIGH = 9'd256;
	localparam logic [CH_W-1:0]    RST_VAL_LOW  = 8'd60;
	localparam logic [BOUND_W-1:0] RST_VAL_HIGH = 9'd256;
	localparam logic [CNT_W-1:0]   RST_MIN_AREA = 21'd1000;

	typedef struct packed {
		logic [CH_W-1:0]    hue_low;
		logic [BOUND_W-1:0] hue_high;
		logic [CH_W-1:0]    sat_low;
		logic [BOUND_W-1:0] sat_high;
		logic [CH_W-1:0]    val_low;
		logic [BOUND_W-1:0] val_high;
		logic [CNT_W-1:0]   min_area;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]    hue;
		logic [CH_W-1:0]    saturation;
		logic [CH_W-1:0]    brightness;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               frame_end;
	} pix_t;

	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic               prior_valid;
		logic [COORD_W-1:0] prior_x;
		logic [COORD_W-1:0] prior_y;
	} res_t;

	typedef struct packed {
		logic accept;    // a pixel transfer completes
		logic close;     // that pixel ends the frame
		logic div_step;  // one divider iteration
		logic emit;      // load the result register
		logic found;     // the result reports an object
	} cmd_t;

	typedef struct packed {
		logic above;     // frame count exceeds min_area
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/color_blob_centroid_tracker.sv =====
// Color blob centroid tracker, top level: register file, controller, datapath.
// Throughput: one pixel transfer per cycle inside a frame. After the pixel that
// ends the frame, the input stalls through the check state, ten divider steps
// and the load when an object is found, the check and the load otherwise,
// longer while a result is held. The result shows in the cycle after the load.
// Reset clears the sums, count, prior centroid and controls; registers reload.
`default_nettype none
module color_blob_centroid_tracker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       pix_valid,
	output logic                            pix_stall,
	input  wire cbct_pkg::pix_t             pix,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output cbct_pkg::res_t                  res,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cbct_pkg::ADDR_W-1:0] paddr,
	input  wire logic [cbct_pkg::DATA_W-1:0] pwdata,
	output logic [cbct_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);
	import cbct_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// Window bounds and the minimum area, written over the APB-style port.
	cbct_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The controller accepts pixels while running and sequences the
	// end-of-frame check, the divider and the result load.
	cbct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.frame_end (pix.frame_end),
		.pix_stall (pix_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath accumulates the moments, divides them one quotient bit per
	// cycle for both axes at once, and holds the prior centroid.
	cbct_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pix    (pix),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

`ifndef SYNTH
	// After the last pixel of a frame the input must stall while the result
	// is worked out.
	a_stall_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> pix_stall)
		else $error("pixel input not stalled after frame end");

	// A frame without an object reports all-zero fields.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.found |-> res.center_x == '0 && res.center_y == '0 &&
		!res.prior_valid && res.prior_x == '0 && res.prior_y == '0)
		else $error("not-found result carries nonzero fields");

	// A new result transfer only starts after a load of the result register.
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd.emit))
		else $error("result valid raised without a load");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/cbct_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on cbct_pkg for the register map and the cfg_t struct.
`default_nettype none
module cbct_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cbct_pkg::ADDR_W-1:0] paddr,
	input  wire logic [cbct_pkg::DATA_W-1:0] pwdata,
	output logic [cbct_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	output cbct_pkg::cfg_t                  cfg
);
	import cbct_pkg::*;

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_low  <= RST_HUE_LOW;
			cfg_q.hue_high <= RST_HUE_HIGH;
			cfg_q.sat_low  <= RST_SAT_LOW;
			cfg_q.sat_high <= RST_SAT_HIGH;
			cfg_q.val_low  <= RST_VAL_LOW;
			cfg_q.val_high <= RST_VAL_HIGH;
			cfg_q.min_area <= RST_MIN_AREA;
		end else if (wr_en) begin
			unique case (idx)
				REG_HUE_LOW:  cfg_q.hue_low  <= pwdata[CH_W-1:0];
				REG_HUE_HIGH: cfg_q.hue_high <= pwdata[BOUND_W-1:0];
				REG_SAT_LOW:  cfg_q.sat_low  <= pwdata[CH_W-1:0];
				REG_SAT_HIGH: cfg_q.sat_high <= pwdata[BOUND_W-1:0];
				REG_VAL_LOW:  cfg_q.val_low  <= pwdata[CH_W-1:0];
				REG_VAL_HIGH: cfg_q.val_high <= pwdata[BOUND_W-1:0];
				REG_MIN_AREA: cfg_q.min_area <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_HUE_LOW:  prdata = DATA_W'(cfg_q.hue_low);
			REG_HUE_HIGH: prdata = DATA_W'(cfg_q.hue_high);
			REG_SAT_LOW:  prdata = DATA_W'(cfg_q.sat_low);
			REG_SAT_HIGH: prdata = DATA_W'(cfg_q.sat_high);
			REG_VAL_LOW:  prdata = DATA_W'(cfg_q.val_low);
			REG_VAL_HIGH: prdata = DATA_W'(cfg_q.val_high);
			REG_MIN_AREA: prdata = DATA_W'(cfg_q.min_area);
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/cbct_dp.sv =====
// Datapath: window test, frame accumulators, shift-subtract divider,
// stored prior centroid and the result register. Depends on cbct_pkg.
`default_nettype none
module cbct_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cbct_pkg::cfg_t cfg,
	input  wire cbct_pkg::pix_t pix,
	input  wire cbct_pkg::cmd_t cmd,
	output cbct_pkg::sts_t      sts,
	output cbct_pkg::res_t      res
);
	import cbct_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sumx_q;
	logic [SUM_W-1:0]   sumy_q;
	logic [CNT_W-1:0]   dcount_q;
	logic [SUM_W-1:0]   divisor_q;
	logic [SUM_W-1:0]   remx_q;
	logic [SUM_W-1:0]   remy_q;
	logic [COORD_W-1:0] quox_q;
	logic [COORD_W-1:0] quoy_q;
	logic [COORD_W-1:0] last_x_q;
	logic [COORD_W-1:0] last_y_q;
	logic               last_valid_q;
	res_t               res_q;

	logic               in_window;
	logic               add;
	logic [CNT_W-1:0]   count_nx;
	logic [SUM_W-1:0]   sumx_nx;
	logic [SUM_W-1:0]   sumy_nx;
	logic               ge_x;
	logic               ge_y;

	// Low bounds are inclusive, high bounds exclusive.
	assign in_window = ({1'b0, pix.hue} >= {1'b0, cfg.hue_low}) &&
	                   ({1'b0, pix.hue} < cfg.hue_high) &&
	                   ({1'b0, pix.saturation} >= {1'b0, cfg.sat_low}) &&
	                   ({1'b0, pix.saturation} < cfg.sat_high) &&
	                   ({1'b0, pix.brightness} >= {1'b0, cfg.val_low}) &&
	                   ({1'b0, pix.brightness} < cfg.val_high) &&
	                   (32'(pix.col) < 32'(MAX_WIDTH)) &&
	                   (32'(pix.row) < 32'(MAX_HEIGHT));

	assign add      = cmd.accept && in_window && (count_q < CNT_W'(COUNT_CAP));
	assign count_nx = add ? count_q + CNT_W'(1) : count_q;
	assign sumx_nx  = add ? sumx_q + SUM_W'(pix.col) : sumx_q;
	assign sumy_nx  = add ? sumy_q + SUM_W'(pix.row) : sumy_q;

	assign ge_x = remx_q >= divisor_q;
	assign ge_y = remy_q >= divisor_q;

	assign sts.above = dcount_q > cfg.min_area;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			sumx_q       <= '0;
			sumy_q       <= '0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_valid_q <= 1'b0;
		end else begin
			if (cmd.close) begin
				count_q <= '0;
				sumx_q  <= '0;
				sumy_q  <= '0;
			end else if (cmd.accept) begin
				count_q <= count_nx;
				sumx_q  <= sumx_nx;
				sumy_q  <= sumy_nx;
			end
			if (cmd.emit && cmd.found) begin
				last_x_q     <= quox_q;
				last_y_q     <= quoy_q;
				last_valid_q <= 1'b1;
			end
		end
	end

	// The divisor starts aligned to the top quotient bit and moves right one
	// place per step; both coordinates share it.
	always_ff @(posedge clk) begin
		if (cmd.close) begin
			dcount_q  <= count_nx;
			divisor_q <= {count_nx, (SUM_W-CNT_W)'(0)};
			remx_q    <= sumx_nx;
			remy_q    <= sumy_nx;
		end else if (cmd.div_step) begin
			divisor_q <= divisor_q >> 1;
			if (ge_x) begin
				remx_q <= remx_q - divisor_q;
			end
			if (ge_y) begin
				remy_q <= remy_q - divisor_q;
			end
			quox_q <= {quox_q[COORD_W-2:0], ge_x};
			quoy_q <= {quoy_q[COORD_W-2:0], ge_y};
		end
		if (cmd.emit) begin
			if (cmd.found) begin
				res_q.found       <= 1'b1;
				res_q.center_x    <= quox_q;
				res_q.center_y    <= quoy_q;
				res_q.prior_valid <= last_valid_q;
				res_q.prior_x     <= last_x_q;
				res_q.prior_y     <= last_y_q;
			end else begin
				res_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/cbct_ctrl.sv =====
// Controller: pixel handshake, end-of-frame sequencing, divider step count
// and the result valid flag. Depends on cbct_pkg for cmd_t and sts_t.
`default_nettype none
module cbct_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pix_valid,
	input  wire logic           frame_end,
	output logic                pix_stall,
	output logic                res_valid,
	input  wire logic           res_stall,
	input  wire cbct_pkg::sts_t sts,
	output cbct_pkg::cmd_t      cmd
);
	import cbct_pkg::*;

	localparam logic [1:0] S_RUN   = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              found_q;
	logic              res_valid_q;
	logic              out_free;

	assign pix_stall    = state_q != S_RUN;
	assign res_valid    = res_valid_q;
	assign out_free     = !res_valid_q || !res_stall;

	assign cmd.accept   = pix_valid && !pix_stall;
	assign cmd.close    = cmd.accept && frame_end;
	assign cmd.div_step = state_q == S_DIV;
	assign cmd.emit     = (state_q == S_EMIT) && out_free;
	assign cmd.found    = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			step_q      <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_RUN: begin
					if (cmd.close) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					found_q <= sts.above;
					step_q  <= STEP_W'(DIV_STEPS - 1);
					state_q <= sts.above ? S_DIV : S_EMIT;
				end
				S_DIV: begin
					if (step_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

endmodule
`default_nettype wire
